[rtl/led_matrix_chain_frame_driver_macros.svh]
// assertion macros used by the frame driver checker
`ifndef LED_MATRIX_CHAIN_FRAME_DRIVER_MACROS_SVH
`define LED_MATRIX_CHAIN_FRAME_DRIVER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LMCFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame driver check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define LMCFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame driver check failed: next-cycle implication");

`endif

[rtl/lmcfd_pkg.sv]
// package: command codes, chip register codes and frame helpers
`timescale 1ns / 1ps

package lmcfd_pkg;

    // command codes
    localparam logic [2:0] CMD_DRAW   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_FLUSH  = 3'd2;
    localparam logic [2:0] CMD_INIT   = 3'd3;
    localparam logic [2:0] CMD_BRIGHT = 3'd4;

    // chip register addresses
    localparam logic [7:0] REG_NO_OP    = 8'h00;
    localparam logic [7:0] REG_ROW_BASE = 8'h01;
    localparam logic [7:0] REG_DECODE   = 8'h09;
    localparam logic [7:0] REG_BRIGHT   = 8'h0A;
    localparam logic [7:0] REG_SCAN     = 8'h0B;
    localparam logic [7:0] REG_POWER    = 8'h0C;
    localparam logic [7:0] REG_TEST     = 8'h0F;

    localparam logic [3:0] BRIGHT_MAX = 4'd15;
    localparam logic [7:0] SCAN_ALL   = 8'd7;

    // frame layout
    localparam int WORD_W      = 16;
    localparam int CHAIN_SLOTS = 4;
    localparam int FRAME_W     = WORD_W * CHAIN_SLOTS;

    // init sequence steps
    localparam logic [2:0] INIT_POWER_OFF = 3'd0;
    localparam logic [2:0] INIT_TEST_OFF  = 3'd1;
    localparam logic [2:0] INIT_SCAN      = 3'd2;
    localparam logic [2:0] INIT_DECODE    = 3'd3;
    localparam logic [2:0] INIT_BRIGHT    = 3'd4;
    localparam logic [2:0] INIT_POWER_ON  = 3'd5;

    // same word in each of the first n slots, zero above
    function automatic logic [FRAME_W-1:0] broadcast(input logic [2:0] n,
                                                     input logic [WORD_W-1:0] w);
        logic [FRAME_W-1:0] f;
        f = '0;
        for (int k = 0; k < CHAIN_SLOTS; k++) begin
            if (3'(k) < n) begin
                f[k*WORD_W +: WORD_W] = w;
            end
        end
        return f;
    endfunction

    // word sent at each step of the init sequence
    function automatic logic [WORD_W-1:0] init_word(input logic [2:0] step,
                                                    input logic [3:0] bright);
        logic [WORD_W-1:0] w;
        case (step)
            INIT_POWER_OFF: w = {REG_POWER, 8'h00};
            INIT_TEST_OFF:  w = {REG_TEST, 8'h00};
            INIT_SCAN:      w = {REG_SCAN, SCAN_ALL};
            INIT_DECODE:    w = {REG_DECODE, 8'h00};
            INIT_BRIGHT:    w = {REG_BRIGHT, 4'h0, bright};
            INIT_POWER_ON:  w = {REG_POWER, 8'h01};
            default:        w = {REG_NO_OP, 8'h00};
        endcase
        return w;
    endfunction

endpackage

[rtl/lmcfd_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module lmcfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/led_matrix_chain_frame_driver.sv]
// top level: column store and frame sequencer for a chain of 8x8 led modules
`timescale 1ns / 1ps

// Commands enter on i_start while o_busy is low. Every frame appears on
// o_frame_words for exactly one cycle with o_frame_strobe, and the receiver
// cannot hold it off, so it must take one frame per cycle. Per item:
// a draw on the panel holds o_busy for one read of the column memory,
// then the write-back; a draw off the panel is dropped without setting
// o_busy; clear leaves o_busy low; set intensity leaves o_busy low and
// its frame appears in the next cycle; init holds o_busy while it sends
// one frame per init step, from power off to power on; flush, for each
// module in use, makes 8 column reads through the memory read port, waits
// for the last read data, then sends 8 row frames. The column memory is
// ready right after reset: per-entry valid bits stand in for the zero
// contents, so there is no clearing pass.
module led_matrix_chain_frame_driver #(
    parameter int MAX_MODULES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_command,
    input  logic signed [7:0] i_x_pos,
    input  logic signed [7:0] i_y_pos,
    input  logic        i_pixel_on,
    input  logic [7:0]  i_level,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    output logic        o_frame_strobe,
    output logic [63:0] o_frame_words,
    output logic        o_last_frame
);

    localparam int STORE_DEPTH = 8 * MAX_MODULES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MOD_W       = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW_WR,
        S_FL_RD,
        S_FL_WAIT,
        S_FL_EMIT,
        S_INIT
    } t_state;

    t_state                      r_state;
    logic [2:0]                  r_module_count;
    logic [3:0]                  r_bright;
    logic [STORE_DEPTH-1:0]      r_valid;
    logic                        r_rd_vld;
    logic [ADDR_W-1:0]           r_draw_addr;
    logic [7:0]                  r_draw_mask;
    logic                        r_draw_on;
    logic [MOD_W-1:0]            r_mod;
    logic [2:0]                  r_col;
    logic [2:0]                  r_row;
    logic [2:0]                  r_step;
    logic                        r_cap_en;
    logic [2:0]                  r_cap_i;
    logic [7:0][7:0]             r_rows;
    logic                        r_strobe;
    logic [lmcfd_pkg::FRAME_W-1:0] r_words;
    logic                        r_last;

    logic              w_accept;
    logic [2:0]        w_mods;
    logic              w_last_mod;
    logic              w_draw_ok;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_ram_q;
    logic [7:0]        w_col;
    logic              w_we;
    logic [7:0]        w_wr_data;
    logic [3:0]        w_level;
    logic [lmcfd_pkg::WORD_W-1:0] w_row_word;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // modules in use, zero counts as one, saturates at the chain length
    always_comb begin
        if (r_module_count == 3'd0) begin
            w_mods = 3'd1;
        end else if (r_module_count > 3'(MAX_MODULES)) begin
            w_mods = 3'(MAX_MODULES);
        end else begin
            w_mods = r_module_count;
        end
    end

    assign w_last_mod = (r_mod == MOD_W'(w_mods - 3'd1));

    // pixel must lie on the modules in use
    assign w_draw_ok = !i_x_pos[7] && (i_x_pos[6:0] < {1'b0, w_mods, 3'b000})
                    && !i_y_pos[7] && (i_y_pos[6:3] == 4'd0);

    assign w_level = (i_level > 8'(lmcfd_pkg::BRIGHT_MAX)) ? lmcfd_pkg::BRIGHT_MAX
                                                          : i_level[3:0];

    // read address: pixel column while idle, module column during flush
    assign w_rd_addr = (r_state == S_FL_RD) ? ADDR_W'({r_mod, r_col})
                                            : ADDR_W'(i_x_pos[6:0]);

    // an entry never written since the last clear reads as zero
    assign w_col = r_rd_vld ? w_ram_q : 8'h00;

    // read-modify-write of one column
    assign w_we      = (r_state == S_DRAW_WR);
    assign w_wr_data = r_draw_on ? (w_col | r_draw_mask) : (w_col & ~r_draw_mask);

    assign w_row_word = {8'(lmcfd_pkg::REG_ROW_BASE + {5'd0, r_row}), r_rows[r_row]};

    lmcfd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (r_draw_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_q)
    );

    // valid flag follows the read data, rows gather the flushed columns
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[w_rd_addr];
        r_cap_i  <= r_col;
        if (r_cap_en) begin
            for (int r = 0; r < 8; r++) begin
                r_rows[r][3'd7 - r_cap_i] <= w_col[r];
            end
        end
    end

    // sequencer, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_module_count <= 3'd4;
            r_bright       <= lmcfd_pkg::BRIGHT_MAX;
            r_valid        <= '0;
            r_strobe       <= 1'b0;
            r_last         <= 1'b0;
            r_cap_en       <= 1'b0;
            r_mod          <= '0;
            r_col          <= '0;
            r_row          <= '0;
            r_step         <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_cap_en <= (r_state == S_FL_RD);
            if (i_cfg_wr_en) begin
                r_module_count <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_command)
                            lmcfd_pkg::CMD_DRAW: begin
                                if (w_draw_ok) begin
                                    r_draw_addr <= ADDR_W'(i_x_pos[6:0]);
                                    r_draw_mask <= 8'd1 << i_y_pos[2:0];
                                    r_draw_on   <= i_pixel_on;
                                    r_state     <= S_DRAW_WR;
                                end
                            end
                            lmcfd_pkg::CMD_CLEAR: begin
                                r_valid <= '0;
                            end
                            lmcfd_pkg::CMD_FLUSH: begin
                                r_mod   <= '0;
                                r_col   <= '0;
                                r_state <= S_FL_RD;
                            end
                            lmcfd_pkg::CMD_INIT: begin
                                r_step  <= lmcfd_pkg::INIT_POWER_OFF;
                                r_state <= S_INIT;
                            end
                            lmcfd_pkg::CMD_BRIGHT: begin
                                r_bright <= w_level;
                                r_strobe <= 1'b1;
                                r_last   <= 1'b1;
                                r_words  <= lmcfd_pkg::broadcast(w_mods,
                                                {lmcfd_pkg::REG_BRIGHT, 4'h0, w_level});
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DRAW_WR: begin
                    r_valid[r_draw_addr] <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_FL_RD: begin
                    r_col <= r_col + 3'd1;
                    if (r_col == 3'd7) begin
                        r_state <= S_FL_WAIT;
                    end
                end
                S_FL_WAIT: begin
                    r_row   <= '0;
                    r_state <= S_FL_EMIT;
                end
                S_FL_EMIT: begin
                    r_strobe <= 1'b1;
                    r_words  <= lmcfd_pkg::FRAME_W'(w_row_word) << {r_mod, 4'b0000};
                    r_row    <= r_row + 3'd1;
                    if (r_row == 3'd7) begin
                        if (w_last_mod) begin
                            r_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_mod   <= r_mod + MOD_W'(1);
                            r_col   <= '0;
                            r_state <= S_FL_RD;
                        end
                    end
                end
                S_INIT: begin
                    r_strobe <= 1'b1;
                    r_words  <= lmcfd_pkg::broadcast(w_mods,
                                    lmcfd_pkg::init_word(r_step, r_bright));
                    r_step   <= r_step + 3'd1;
                    if (r_step == lmcfd_pkg::INIT_POWER_ON) begin
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_frame_strobe = r_strobe;
    assign o_frame_words  = r_words;
    assign o_last_frame   = r_last;

endmodule

[rtl/lmcfd_checker.sv]
// port-level checks for the frame driver, bound to the top level
`timescale 1ns / 1ps
`include "led_matrix_chain_frame_driver_macros.svh"

module lmcfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [2:0]  i_command,
    input logic        o_frame_strobe,
    input logic [63:0] o_frame_words,
    input logic        o_last_frame
);

    // a last flag never stands without a frame
    `LMCFD_ASSERT_IMP(a_last_has_strobe, i_clk, i_rst_n, o_last_frame, o_frame_strobe)

    // init keeps the block busy while its frames go out
    `LMCFD_ASSERT_NXT(a_init_busy, i_clk, i_rst_n, i_start && !o_busy && (i_command == lmcfd_pkg::CMD_INIT), o_busy)

    // set intensity gives exactly one brightness frame in the next cycle
    `LMCFD_ASSERT_NXT(a_bright_frame, i_clk, i_rst_n, i_start && !o_busy && (i_command == lmcfd_pkg::CMD_BRIGHT), o_frame_strobe && o_last_frame && (o_frame_words[15:8] == lmcfd_pkg::REG_BRIGHT))

    // a draw sends nothing
    `LMCFD_ASSERT_NXT(a_draw_silent, i_clk, i_rst_n, i_start && !o_busy && (i_command == lmcfd_pkg::CMD_DRAW), !o_frame_strobe)

    // the first cycle out of reset is idle and quiet
    `LMCFD_ASSERT_IMP(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_busy && !o_frame_strobe)

endmodule

bind led_matrix_chain_frame_driver lmcfd_checker u_lmcfd_checker (.*);

[test/tb_top.sv]
// testbench for the led matrix chain frame driver: directed table, then random commands
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_MODULES  = 4;
    localparam int STORE_DEPTH  = 32;
    localparam int DRAIN_CYCLES = 17 * MAX_MODULES + 12;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 25;
    localparam int NUM_PHASES   = 8;
    localparam int NUM_ROWS     = 22;

    // command codes the block ignores
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        EXP_PRED,
        EXP_NONE,
        EXP_ONE
    } t_exp_kind;

    typedef struct packed {
        logic [63:0] words;
        logic        last;
    } t_frame;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        pix;
        logic [7:0]  lvl;
        t_exp_kind   kind;
        logic [63:0] frame;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [2:0]  i_command = '0;
    logic signed [7:0] i_x_pos = '0;
    logic signed [7:0] i_y_pos = '0;
    logic        i_pixel_on = 1'b0;
    logic [7:0]  i_level = '0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_wr_data = '0;
    logic        o_frame_strobe;
    logic [63:0] o_frame_words;
    logic        o_last_frame;

    // shadow state of the block
    logic [7:0]  column_bytes [STORE_DEPTH];
    logic [3:0]  shadow_bright;
    logic [2:0]  shadow_modules;

    t_frame      pending_frames [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    led_matrix_chain_frame_driver #(
        .MAX_MODULES(MAX_MODULES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_pixel_on     (i_pixel_on),
        .i_level        (i_level),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_frame_strobe (o_frame_strobe),
        .o_frame_words  (o_frame_words),
        .o_last_frame   (o_last_frame)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // modules in use after clamping the register
    function automatic int modules_in_use();
        if (shadow_modules == 3'd0) begin
            return 1;
        end
        if (int'(shadow_modules) > MAX_MODULES) begin
            return MAX_MODULES;
        end
        return int'(shadow_modules);
    endfunction

    // same word in every used slot
    function automatic logic [63:0] chain_word(input logic [7:0] reg_addr,
                                               input logic [7:0] data);
        logic [63:0] f;
        int n;
        f = '0;
        n = modules_in_use();
        for (int k = 0; k < n; k++) begin
            f[k*16 +: 16] = {reg_addr, data};
        end
        return f;
    endfunction

    task automatic queue_frame(input logic [63:0] words);
        t_frame fr;
        fr.words = words;
        fr.last  = 1'b0;
        pending_frames.push_back(fr);
    endtask

    // update shadow state and queue the frames one command causes
    task automatic predict_frames(input logic [2:0] cmd, input logic [7:0] x,
                                  input logic [7:0] y, input logic pix,
                                  input logic [7:0] lvl);
        int n;
        int start_size;
        int xs;
        int ys;
        logic [7:0] row_byte;
        logic [3:0] lv;
        t_frame fr;
        n = modules_in_use();
        start_size = pending_frames.size();
        xs = int'($signed(x));
        ys = int'($signed(y));
        case (cmd)
            lmcfd_pkg::CMD_DRAW: begin
                if (xs >= 0 && xs < n * 8 && ys >= 0 && ys < 8) begin
                    column_bytes[xs][ys] = pix;
                end
            end
            lmcfd_pkg::CMD_CLEAR: begin
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    column_bytes[i] = '0;
                end
            end
            lmcfd_pkg::CMD_FLUSH: begin
                // row r of each module gathers bit r of its columns, column 0 in bit 7
                for (int d = 0; d < n; d++) begin
                    for (int r = 0; r < 8; r++) begin
                        for (int i = 0; i < 8; i++) begin
                            row_byte[7-i] = column_bytes[d*8+i][r];
                        end
                        queue_frame(64'({lmcfd_pkg::REG_ROW_BASE + 8'(r), row_byte})
                                    << (16 * d));
                    end
                end
            end
            lmcfd_pkg::CMD_INIT: begin
                queue_frame(chain_word(lmcfd_pkg::REG_POWER, 8'h00));
                queue_frame(chain_word(lmcfd_pkg::REG_TEST, 8'h00));
                queue_frame(chain_word(lmcfd_pkg::REG_SCAN, lmcfd_pkg::SCAN_ALL));
                queue_frame(chain_word(lmcfd_pkg::REG_DECODE, 8'h00));
                queue_frame(chain_word(lmcfd_pkg::REG_BRIGHT, {4'h0, shadow_bright}));
                queue_frame(chain_word(lmcfd_pkg::REG_POWER, 8'h01));
            end
            lmcfd_pkg::CMD_BRIGHT: begin
                lv = (lvl > 8'(lmcfd_pkg::BRIGHT_MAX)) ? lmcfd_pkg::BRIGHT_MAX : lvl[3:0];
                shadow_bright = lv;
                queue_frame(chain_word(lmcfd_pkg::REG_BRIGHT, {4'h0, lv}));
            end
            default: begin
            end
        endcase
        // mark the final frame of this command
        if (pending_frames.size() > start_size) begin
            fr = pending_frames.pop_back();
            fr.last = 1'b1;
            pending_frames.push_back(fr);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_frame_strobe) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected frame", o_frame_words, 64'h0);
            end else begin
                want = pending_frames.pop_front();
                if (o_frame_words !== want.words) begin
                    report_mismatch("frame_words", o_frame_words, want.words);
                end
                if (o_last_frame !== want.last) begin
                    report_mismatch("last_frame", 64'(o_last_frame), 64'(want.last));
                end
            end
        end
    end

    // watchdog on cycles with no item and no frame
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_frame_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // drive one item and return at the edge that accepts it
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] x,
                             input logic [7:0] y, input logic pix,
                             input logic [7:0] lvl, input bit allow_gap);
        int gap;
        gap = 0;
        @(negedge i_clk);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start    <= 1'b1;
        i_command  <= cmd;
        i_x_pos    <= x;
        i_y_pos    <= y;
        i_pixel_on <= pix;
        i_level    <= lvl;
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    // stop sending, wait for all frames, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_modules(input logic [2:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_modules = value;
    endtask

    function automatic t_stim_row make_row(input logic [2:0] cmd, input logic [7:0] x,
                                           input logic [7:0] y, input logic pix,
                                           input logic [7:0] lvl, input t_exp_kind kind,
                                           input logic [63:0] frame);
        t_stim_row row;
        row.cmd   = cmd;
        row.x     = x;
        row.y     = y;
        row.pix   = pix;
        row.lvl   = lvl;
        row.kind  = kind;
        row.frame = frame;
        return row;
    endfunction

    // directed stimulus, four modules in use
    function automatic t_stim_row directed_row(input int k);
        case (k)
            0:  return make_row(lmcfd_pkg::CMD_FLUSH,  8'd0,  8'd0,  1'b0, 8'd0,
                                EXP_PRED, 64'h0);
            1:  return make_row(lmcfd_pkg::CMD_BRIGHT, 8'hff, 8'hff, 1'b1, 8'd255,
                                EXP_ONE, 64'h0a0f_0a0f_0a0f_0a0f);
            2:  return make_row(lmcfd_pkg::CMD_BRIGHT, 8'd0,  8'd0,  1'b0, 8'd0,
                                EXP_ONE, 64'h0a00_0a00_0a00_0a00);
            3:  return make_row(lmcfd_pkg::CMD_INIT,   8'd0,  8'd0,  1'b0, 8'd0,
                                EXP_PRED, 64'h0);
            4:  return make_row(lmcfd_pkg::CMD_DRAW,   8'd0,  8'd0,  1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            5:  return make_row(lmcfd_pkg::CMD_DRAW,   8'd31, 8'd7,  1'b1, 8'hff,
                                EXP_NONE, 64'h0);
            6:  return make_row(lmcfd_pkg::CMD_DRAW,   8'h80, 8'd0,  1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            7:  return make_row(lmcfd_pkg::CMD_DRAW,   8'h7f, 8'h7f, 1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            8:  return make_row(lmcfd_pkg::CMD_DRAW,   8'd5,  8'hff, 1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            9:  return make_row(lmcfd_pkg::CMD_DRAW,   8'd32, 8'd3,  1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            10: return make_row(lmcfd_pkg::CMD_DRAW,   8'd10, 8'd3,  1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            11: return make_row(lmcfd_pkg::CMD_DRAW,   8'd10, 8'd3,  1'b0, 8'd0,
                                EXP_NONE, 64'h0);
            12: return make_row(lmcfd_pkg::CMD_DRAW,   8'd17, 8'd4,  1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            13: return make_row(lmcfd_pkg::CMD_DRAW,   8'd8,  8'd8,  1'b1, 8'd0,
                                EXP_NONE, 64'h0);
            14: return make_row(lmcfd_pkg::CMD_FLUSH,  8'hff, 8'h80, 1'b1, 8'hff,
                                EXP_PRED, 64'h0);
            15: return make_row(CMD_RSVD5, 8'd1, 8'd1, 1'b1, 8'd9, EXP_NONE, 64'h0);
            16: return make_row(CMD_RSVD6, 8'd2, 8'd2, 1'b1, 8'd9, EXP_NONE, 64'h0);
            17: return make_row(CMD_RSVD7, 8'd3, 8'd3, 1'b1, 8'd9, EXP_NONE, 64'h0);
            18: return make_row(lmcfd_pkg::CMD_BRIGHT, 8'd0,  8'd0,  1'b0, 8'd15,
                                EXP_ONE, 64'h0a0f_0a0f_0a0f_0a0f);
            19: return make_row(lmcfd_pkg::CMD_BRIGHT, 8'd0,  8'd0,  1'b0, 8'd16,
                                EXP_ONE, 64'h0a0f_0a0f_0a0f_0a0f);
            20: return make_row(lmcfd_pkg::CMD_INIT,   8'h55, 8'haa, 1'b1, 8'h33,
                                EXP_PRED, 64'h0);
            default: return make_row(lmcfd_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0,
                                     EXP_NONE, 64'h0);
        endcase
    endfunction

    // random item, mostly pixel draws on the panel
    task automatic send_random(input bit allow_gap);
        int pick;
        int n;
        logic [2:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] lvl;
        logic pix;
        n = modules_in_use();
        pick = $urandom_range(0, 99);
        x = 8'($urandom);
        y = 8'($urandom);
        lvl = 8'($urandom);
        pix = 1'($urandom);
        if (pick < 70) begin
            cmd = lmcfd_pkg::CMD_DRAW;
            if ($urandom_range(0, 9) < 8) begin
                x = 8'($urandom_range(0, n * 8 - 1));
                y = 8'($urandom_range(0, 7));
            end
        end else if (pick < 81) begin
            cmd = lmcfd_pkg::CMD_FLUSH;
        end else if (pick < 86) begin
            cmd = lmcfd_pkg::CMD_INIT;
        end else if (pick < 93) begin
            cmd = lmcfd_pkg::CMD_BRIGHT;
            if ($urandom_range(0, 1) == 0) begin
                lvl = 8'($urandom_range(0, 15));
            end
        end else if (pick < 96) begin
            cmd = lmcfd_pkg::CMD_CLEAR;
        end else begin
            cmd = CMD_RSVD5 + 3'($urandom_range(0, 2));
        end
        send_item(cmd, x, y, pix, lvl, allow_gap);
        predict_frames(cmd, x, y, pix, lvl);
    endtask

    // main sequence
    initial begin
        t_stim_row row;
        int mark;
        bit idle_on;
        logic [2:0] phase_modules [NUM_PHASES];
        t_frame fr;

        phase_modules[0] = 3'd1;
        phase_modules[1] = 3'd0;
        phase_modules[2] = 3'd2;
        phase_modules[3] = 3'd3;
        phase_modules[4] = 3'd7;
        phase_modules[5] = 3'd5;
        phase_modules[6] = 3'd6;
        phase_modules[7] = 3'd4;

        // reset and shadow state
        for (int i = 0; i < STORE_DEPTH; i++) begin
            column_bytes[i] = '0;
        end
        shadow_bright  = lmcfd_pkg::BRIGHT_MAX;
        shadow_modules = 3'd4;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < NUM_ROWS; k++) begin
            row = directed_row(k);
            send_item(row.cmd, row.x, row.y, row.pix, row.lvl, 1'b1);
            mark = pending_frames.size();
            predict_frames(row.cmd, row.x, row.y, row.pix, row.lvl);
            if (row.kind != EXP_PRED) begin
                while (pending_frames.size() > mark) begin
                    void'(pending_frames.pop_back());
                end
                if (row.kind == EXP_ONE) begin
                    fr.words = row.frame;
                    fr.last  = 1'b1;
                    pending_frames.push_back(fr);
                end
            end
        end

        // random phases over module counts, the fourth and the last phase without gaps
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_modules(phase_modules[p]);
            idle_on = (p != 3) && (p != NUM_PHASES - 1);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                send_random(idle_on);
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/lmcfd_pkg.sv
rtl/lmcfd_ram.sv
rtl/led_matrix_chain_frame_driver.sv
rtl/lmcfd_checker.sv
test/tb_top.sv
